// ===== rtl/core/animation_slot_time_lookup_macros.svh =====
// ---------------------------------------------------------------------------
// animation slot time lookup assertion macros
// overlapping implication and next-cycle implication checks on clock/reset
// ---------------------------------------------------------------------------
`ifndef ANIMATION_SLOT_TIME_LOOKUP_MACROS_SVH
`define ANIMATION_SLOT_TIME_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
`define ASTL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASTL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next cycle check failed");
`else
`define ASTL_ASSERT_IMP(lbl, ante, cons)
`define ASTL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/astl_pkg.sv =====
// ---------------------------------------------------------------------------
// astl_pkg
// shared types, codes and helpers of the animation slot time lookup
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package astl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam logic [15:0] LENGTH_LIMIT = 16'd255;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_SLOTS = 2'd1,
      ERR_RANGE    = 2'd2,
      ERR_LENGTH   = 2'd3
   } astl_err_type;

   typedef struct packed {
      logic       action;
      logic [7:0] slot_index;
      logic [7:0] sustain;
      logic [7:0] time_index;
   } astl_req_type;

   typedef struct packed {
      logic [7:0]   slot_for_time;
      logic [7:0]   first_time;
      logic [15:0]  total_length;
      astl_err_type error;
   } astl_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } astl_wr_type;

   // a sustain of zero lasts one tick
   function automatic logic [7:0] astl_tick(input logic [7:0] s);
      astl_tick = (s == 8'd0) ? 8'd1 : s;
   endfunction

endpackage

// ===== rtl/core/astl_table.sv =====
// ---------------------------------------------------------------------------
// astl_table
// sustain table: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module astl_table (
   input  logic                      clock,
   input  astl_pkg::astl_wr_type     wr,
   input  logic [astl_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import astl_pkg::*;

   logic [7:0] mem [TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/animation_slot_time_lookup.sv =====
// a write request, or a query with no slots, answers in the next cycle.
// a query makes one table pass for the total, a restoring remainder step, then a second
// pass until the slot is found; a length or range error answers after the first pass.
// one table entry per cycle, one request at a time; reset clears the slot count and
// control state, table contents stay until written; the receiver cannot stall.
`timescale 1ns / 1ps
`include "animation_slot_time_lookup_macros.svh"

// ---------------------------------------------------------------------------
// animation_slot_time_lookup
// sustain table with slot walk, time wrap and first-time lookup
// ---------------------------------------------------------------------------
module animation_slot_time_lookup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  astl_pkg::astl_req_type req_data,
   output logic                   rsp_valid,
   output astl_pkg::astl_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata
);
   import astl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_MOD,
      ST_WALK
   } state_type;

   state_type    state_ff;
   astl_req_type req_ff;
   logic [7:0]   num_slots_ff;
   logic [ADDR_W-1:0] iss_ff;
   logic         pv_ff;
   logic [ADDR_W-1:0] pidx_ff;
   logic [15:0]  acc_ff;
   logic [7:0]   first_ff;
   logic [7:0]   rem_ff;
   logic [2:0]   bit_ff;
   logic [8:0]   run_ff;
   logic         rsp_valid_ff;
   astl_rsp_type rsp_ff;

   astl_wr_type  wr;
   logic [7:0]   rd_data;
   logic [7:0]   tick_w;
   logic [15:0]  acc_in;
   logic [8:0]   run_in;
   logic [8:0]   rem_shift;
   logic [8:0]   rem_sub;
   logic [7:0]   rem_in;
   logic         issue_ok;
   logic         last_w;
   logic         accept;

   astl_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (iss_ff),
      .rd_data (rd_data)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign wr.en    = accept && (req_data.action == ACT_WRITE);
   assign wr.addr  = req_data.slot_index[ADDR_W-1:0];
   assign wr.data  = req_data.sustain;

   assign tick_w   = astl_tick(rd_data);
   assign acc_in   = acc_ff + {8'd0, tick_w};
   assign run_in   = run_ff + {1'b0, tick_w};
   assign issue_ok = {1'b0, iss_ff} < {1'b0, num_slots_ff};
   assign last_w   = {1'b0, pidx_ff} == ({1'b0, num_slots_ff} - 9'd1);

   // restoring remainder, one dividend bit per cycle
   assign rem_shift = {rem_ff, req_ff.time_index[bit_ff]};
   assign rem_sub   = rem_shift - {1'b0, acc_ff[7:0]};
   assign rem_in    = (rem_shift >= {1'b0, acc_ff[7:0]}) ? rem_sub[7:0] : rem_shift[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_slots_ff <= 8'd0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            num_slots_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff   <= req_data;
                  iss_ff   <= '0;
                  pv_ff    <= 1'b0;
                  acc_ff   <= 16'd0;
                  first_ff <= 8'd0;
                  if (req_data.action == ACT_WRITE) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{8'd0, 8'd0, 16'd0, ERR_NONE};
                  end else if (num_slots_ff == 8'd0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{8'd0, 8'd0, 16'd0, ERR_NO_SLOTS};
                  end else begin
                     state_ff <= ST_SUM;
                  end
               end
            end
            ST_SUM: begin
               if (issue_ok) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               pv_ff   <= issue_ok;
               pidx_ff <= iss_ff;
               if (pv_ff) begin
                  acc_ff <= acc_in;
                  // running sum before this entry is the slot's first time
                  if (pidx_ff == req_ff.slot_index[ADDR_W-1:0]) begin
                     first_ff <= acc_ff[7:0];
                  end
                  if (last_w) begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (acc_ff >= LENGTH_LIMIT) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{8'd0, 8'd0, acc_ff, ERR_LENGTH};
                  state_ff     <= ST_IDLE;
               end else if (req_ff.slot_index >= num_slots_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{8'd0, 8'd0, acc_ff, ERR_RANGE};
                  state_ff     <= ST_IDLE;
               end else begin
                  rem_ff   <= 8'd0;
                  bit_ff   <= 3'd7;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               rem_ff <= rem_in;
               bit_ff <= bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  iss_ff   <= '0;
                  pv_ff    <= 1'b0;
                  run_ff   <= 9'd0;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (issue_ok) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               pv_ff   <= issue_ok;
               pidx_ff <= iss_ff;
               if (pv_ff) begin
                  run_ff <= run_in;
                  if ({1'b0, rem_ff} < run_in) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{8'(pidx_ff), first_ff, acc_ff, ERR_NONE};
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASTL_ASSERT_IMP(a_err_zero_fields,
      rsp_valid && (rsp_data.error != ERR_NONE),
      (rsp_data.slot_for_time == 8'd0) && (rsp_data.first_time == 8'd0))
   `ASTL_ASSERT_IMP(a_no_slots_total,
      rsp_valid && (rsp_data.error == ERR_NO_SLOTS), rsp_data.total_length == 16'd0)
   `ASTL_ASSERT_NXT(a_accept_progress, start && !busy, busy || rsp_valid)
   `ASTL_ASSERT_IMP(a_walk_in_range,
      (state_ff == ST_WALK) && pv_ff, {1'b0, pidx_ff} < {1'b0, num_slots_ff})

endmodule

// ===== tb/animation_slot_time_lookup_tb.sv =====
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// animation_slot_time_lookup_tb
// drives sustain writes and time queries through the command port, changes
// the slot count between phases, and checks every result field against an
// in-bench model of the sustain table walk, wrap and first-time lookup
// ---------------------------------------------------------------------------
module animation_slot_time_lookup_tb;

   import astl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TARGET_REQUESTS = 650;
   localparam int SETTLE_CYCLES = 600;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   astl_req_type req_data = '0;
   logic         rsp_valid;
   astl_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_wdata = 8'd0;

   // model state
   logic [7:0]   sustain_mem [TABLE_DEPTH];
   int unsigned  slot_count = 0;
   astl_rsp_type pending_rsp [$];

   int unsigned  burst_left = 0;
   int unsigned  stall_cycles = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  writes_sent = 0;
   int unsigned  queries_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  err_seen [4] = '{0, 0, 0, 0};

   animation_slot_time_lookup DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic astl_req_type write_req(input int unsigned slot, input int unsigned sus);
      astl_req_type r;
      r.action     = ACT_WRITE;
      r.slot_index = 8'(slot);
      r.sustain    = 8'(sus);
      r.time_index = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic astl_req_type query_req(input int unsigned slot, input int unsigned tix);
      astl_req_type r;
      r.action     = ACT_QUERY;
      r.slot_index = 8'(slot);
      r.sustain    = 8'($urandom_range(0, 255));
      r.time_index = 8'(tix);
      return r;
   endfunction

   // expected result of one request against the current table and slot count
   function automatic astl_rsp_type lookup_slot_time(input astl_req_type r);
      astl_rsp_type res;
      int unsigned  total;
      int unsigned  run;
      int unsigned  wrapped;
      int unsigned  k;
      bit           hit;
      res = '0;
      if (r.action == ACT_WRITE) begin
         return res;
      end
      total = 0;
      for (k = 0; k < slot_count; k++) begin
         total += (sustain_mem[k] == 8'd0) ? 1 : sustain_mem[k];
      end
      res.total_length = 16'(total);
      if (slot_count == 0) begin
         res.error = ERR_NO_SLOTS;
      end else if (total >= LENGTH_LIMIT) begin
         res.error = ERR_LENGTH;
      end else if (r.slot_index >= slot_count) begin
         res.error = ERR_RANGE;
      end else begin
         res.error = ERR_NONE;
         wrapped = r.time_index % total;
         run = 0;
         k = 0;
         hit = 1'b0;
         while (!hit) begin
            run += (sustain_mem[k] == 8'd0) ? 1 : sustain_mem[k];
            if (wrapped < run) begin
               hit = 1'b1;
            end else begin
               k++;
            end
         end
         res.slot_for_time = 8'(k);
         run = 0;
         for (k = 0; k < r.slot_index; k++) begin
            run += (sustain_mem[k] == 8'd0) ? 1 : sustain_mem[k];
         end
         res.first_time = 8'(run);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // called at a rising edge; returns at the edge that accepted the request, with start
   // still high, when the burst goes on, else drops start and waits a random idle gap first
   task automatic send_request(input astl_req_type r);
      astl_rsp_type exp_rsp;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_rsp = lookup_slot_time(r);
      pending_rsp.push_back(exp_rsp);
      if (r.action == ACT_WRITE) begin
         sustain_mem[r.slot_index] = r.sustain;
         writes_sent++;
      end else begin
         err_seen[int'(exp_rsp.error)]++;
         queries_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 6);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_slot_count(input int unsigned n);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= 8'(n);
      @(posedge clock);
      csr_we     <= 1'b0;
      slot_count = n;
   endtask

   task automatic load_sustains(input int unsigned n, input int unsigned top);
      int unsigned k;
      for (k = 0; k < n; k++) begin
         send_request(write_req(k, $urandom_range(0, top)));
      end
   endtask

   task automatic test_empty_table();
      send_request(query_req(0, 0));
      send_request(query_req(255, 255));
      send_request(write_req(0, 0));
      send_request(write_req(255, 255));
   endtask

   task automatic test_directed_walk();
      // ticks 1, 3, 1, 5: total 10
      send_request(write_req(0, 0));
      send_request(write_req(1, 3));
      send_request(write_req(2, 1));
      send_request(write_req(3, 5));
      set_slot_count(4);
      send_request(query_req(0, 0));
      send_request(query_req(3, 9));
      send_request(query_req(1, 10));
      send_request(query_req(2, 255));
      send_request(query_req(4, 0));
      send_request(query_req(255, 7));
      // overflow wins over a slot out of range
      send_request(write_req(3, 255));
      send_request(query_req(0, 3));
      send_request(query_req(9, 3));
      // total of exactly the limit, then one below it
      send_request(write_req(3, 250));
      send_request(query_req(1, 100));
      send_request(write_req(3, 249));
      send_request(query_req(3, 253));
      send_request(query_req(0, 254));
      set_slot_count(1);
      send_request(query_req(0, 200));
      send_request(query_req(1, 0));
   endtask

   task automatic test_long_tables();
      int unsigned i;
      load_sustains(255, 1);
      set_slot_count(254);
      send_request(query_req(253, 253));
      send_request(query_req(0, 255));
      for (i = 0; i < 4; i++) begin
         send_request(query_req($urandom_range(0, 253), $urandom_range(0, 255)));
      end
      set_slot_count(255);
      send_request(query_req(254, 255));
      send_request(query_req(0, 0));
      set_slot_count(128);
      send_request(query_req(127, 255));
      send_request(query_req(128, 127));
      send_request(query_req($urandom_range(0, 127), $urandom_range(0, 255)));
   endtask

   task automatic test_random_phases();
      int unsigned n;
      int unsigned top;
      int unsigned pick;
      int unsigned i;
      int unsigned count;
      while (writes_sent + queries_sent < TARGET_REQUESTS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            n = 0;
         end else if (pick == 1) begin
            n = $urandom_range(25, 60);
         end else begin
            n = $urandom_range(1, 24);
         end
         // keep the total under the limit in most phases
         top = (n == 0 || $urandom_range(0, 4) == 0) ? 255 : 254 / n;
         set_slot_count(n);
         load_sustains(n, top);
         count = $urandom_range(8, 30);
         for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               send_request(write_req($urandom_range(0, 255), $urandom_range(0, top)));
            end else if (pick < 4 || n == 0) begin
               send_request(query_req($urandom_range(0, 255), $urandom_range(0, 255)));
            end else begin
               send_request(query_req($urandom_range(0, n - 1), $urandom_range(0, 255)));
            end
         end
      end
   endtask

   // result checker: the receiver never stalls
   always @(posedge clock) begin
      astl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with no request", rsp_data.total_length, 16'd0);
         end else begin
            want = pending_rsp.pop_front();
            results_checked++;
            if (rsp_data.slot_for_time !== want.slot_for_time)
               report_mismatch("slot_for_time", rsp_data.slot_for_time, want.slot_for_time);
            if (rsp_data.first_time !== want.first_time)
               report_mismatch("first_time", rsp_data.first_time, want.first_time);
            if (rsp_data.total_length !== want.total_length)
               report_mismatch("total_length", rsp_data.total_length, want.total_length);
            if (rsp_data.error !== want.error)
               report_mismatch("error", rsp_data.error, want.error);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result for %0d cycles", stall_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_walk();
      test_long_tables();
      test_random_phases();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d writes, %0d queries, %0d results checked",
               writes_sent + queries_sent, writes_sent, queries_sent, results_checked);
      $display("query outcomes: ok %0d, no slots %0d, out of range %0d, overflow %0d",
               err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
